### sv/hds_pkg.sv
`timescale 1ns / 1ps
// Package for the 2D heat diffusion stencil: stencil item type, register map,
// queue depth and fixed arithmetic widths. No dependencies.
package hds_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned ROW_W      = 16;
	localparam int unsigned COL_OUT_W  = 10;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned COLS_CFG_W = 11;

	// Laplacian fits in 36 signed bits: four 32-bit terms minus four times a fifth.
	localparam int unsigned LAP_W  = 36;
	localparam int unsigned PROD_W = LAP_W + GAIN_W + 1;
	localparam int unsigned SUM_W  = PROD_W - GAIN_W + 1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_GRID_ROWS = 2'd0,
		REG_GRID_COLS = 2'd1,
		REG_GAIN      = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	localparam logic [ROW_W-1:0]      ROWS_RESET = 16'd21;
	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd21;
	localparam logic [GAIN_W-1:0]     GAIN_RESET = 16'd13107;

	// One complete five-point neighborhood, ready for the update arithmetic.
	typedef struct packed {
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] up;
		logic signed [DATA_W-1:0] down;
		logic signed [DATA_W-1:0] left;
		logic signed [DATA_W-1:0] right;
		logic [ROW_W-1:0]         row;
		logic [COL_OUT_W-1:0]     col;
		logic                     last;
	} stencil_t;

endpackage

### sv/hds_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds when no read is issued. No dependencies.
module hds_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/hds_queue.sv
`timescale 1ns / 1ps
// Short flip-flop queue of stencil items between the front and the back end.
// Depends on hds_pkg.
module hds_queue
	import hds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  stencil_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output stencil_t head
);

	stencil_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= QPTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
			end
			if (do_pop) begin
				rd_ptr_q <= QPTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/hds_front.sv
`timescale 1ns / 1ps
// Front end: accepts cells, tracks the raster position, keeps the two line
// buffers and the neighbor window, and pushes complete stencils to the queue.
// Depends on hds_pkg and hds_ram.
module hds_front
	import hds_pkg::*;
#(
	parameter int unsigned MAX_COLS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [DATA_W-1:0]            in_cell,
	input  logic [ROW_W-1:0]             last_row,
	input  logic [$clog2(MAX_COLS)-1:0]  last_col,
	output logic                         push,
	output stencil_t                     push_item,
	input  logic                         q_full
);

	localparam int unsigned CW = $clog2(MAX_COLS);
	localparam int unsigned CX = (CW > COL_OUT_W) ? CW : COL_OUT_W;

	logic [ROW_W-1:0]    row_q;
	logic [CW-1:0]       col_q;
	logic                accept;

	logic                valid_s1;
	logic                res_s1;
	logic                last_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [CW-1:0]       col_s1;
	logic [DATA_W-1:0]   cell_s1;
	logic                adv_s1;

	// Window: top/mid/bottom of the previous column and the mid of the one before.
	logic [DATA_W-1:0]   top1_q;
	logic [DATA_W-1:0]   mid1_q;
	logic [DATA_W-1:0]   bot1_q;
	logic [DATA_W-1:0]   mid2_q;

	logic [2*DATA_W-1:0] rd_data;
	logic [DATA_W-1:0]   mid_rd;
	logic [DATA_W-1:0]   top_rd;
	logic [CX-1:0]       col_ext;

	assign adv_s1   = valid_s1 && (!res_s1 || !q_full);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// Each line buffer entry holds the pair {row r-1, row r-2} for one column.
	hds_ram #(
		.WIDTH (2 * DATA_W),
		.DEPTH (MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata ({cell_s1, mid_rd}),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	assign mid_rd  = rd_data[2*DATA_W-1:DATA_W];
	assign top_rd  = rd_data[DATA_W-1:0];
	assign col_ext = CX'(col_s1) - 1'b1;

	assign push = adv_s1 && res_s1;
	always_comb begin
		push_item.v     = mid1_q;
		push_item.up    = top1_q;
		push_item.down  = bot1_q;
		push_item.left  = mid2_q;
		push_item.right = mid_rd;
		push_item.row   = row_s1 - 1'b1;
		push_item.col   = col_ext[COL_OUT_W-1:0];
		push_item.last  = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
			last_s1  <= 1'b0;
			row_s1   <= '0;
			col_s1   <= '0;
			cell_s1  <= '0;
			top1_q   <= '0;
			mid1_q   <= '0;
			bot1_q   <= '0;
			mid2_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				res_s1   <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
				last_s1  <= (row_q >= last_row) && (col_q >= last_col);
				row_s1   <= row_q;
				col_s1   <= col_q;
				cell_s1  <= in_cell;
				if (col_q >= last_col) begin
					col_q <= '0;
					row_q <= (row_q >= last_row) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				mid2_q <= mid1_q;
				top1_q <= top_rd;
				mid1_q <= mid_rd;
				bot1_q <= cell_s1;
			end
		end
	end

endmodule

### sv/hds_back.sv
`timescale 1ns / 1ps
// Back end: Laplacian, gain multiply with rounding, add and saturate, then the
// output register. Three stages, each held only when full. Depends on hds_pkg.
module hds_back
	import hds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [GAIN_W-1:0]    gain,
	input  logic                 q_empty,
	input  stencil_t             q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    out_value,
	output logic [ROW_W-1:0]     out_row,
	output logic [COL_OUT_W-1:0] out_col,
	output logic                 out_last
);

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (GAIN_W - 1);
	localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'(32'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0]  SAT_MIN    = SUM_W'(32'sh8000_0000);

	logic                     valid_s1;
	logic signed [LAP_W-1:0]  lap_s1;
	logic signed [DATA_W-1:0] v_s1;
	logic [ROW_W-1:0]         row_s1;
	logic [COL_OUT_W-1:0]     col_s1;
	logic                     last_s1;

	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DATA_W-1:0] v_s2;
	logic [ROW_W-1:0]         row_s2;
	logic [COL_OUT_W-1:0]     col_s2;
	logic                     last_s2;

	logic                     en3;
	logic                     en2;
	logic                     en1;
	logic signed [LAP_W-1:0]  lap;
	logic signed [SUM_W-1:0]  sum;

	assign en3   = !out_valid || out_ready;
	assign en2   = !valid_s2 || en3;
	assign en1   = !valid_s1 || en2;
	assign q_pop = en1 && !q_empty;

	always_comb begin
		lap = LAP_W'(q_head.up) + LAP_W'(q_head.down) + LAP_W'(q_head.left)
			+ LAP_W'(q_head.right) - (LAP_W'(q_head.v) <<< 2);
		sum = SUM_W'(v_s2) + SUM_W'(prod_s2 >>> GAIN_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
			lap_s1    <= '0;
			v_s1      <= '0;
			row_s1    <= '0;
			col_s1    <= '0;
			last_s1   <= 1'b0;
			prod_s2   <= '0;
			v_s2      <= '0;
			row_s2    <= '0;
			col_s2    <= '0;
			last_s2   <= 1'b0;
			out_value <= '0;
			out_row   <= '0;
			out_col   <= '0;
			out_last  <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= !q_empty;
				lap_s1   <= lap;
				v_s1     <= q_head.v;
				row_s1   <= q_head.row;
				col_s1   <= q_head.col;
				last_s1  <= q_head.last;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
				// Round to nearest, ties upward: add one half before the floor shift.
				prod_s2  <= PROD_W'(lap_s1) * $signed({1'b0, gain}) + ROUND_HALF;
				v_s2     <= v_s1;
				row_s2   <= row_s1;
				col_s2   <= col_s1;
				last_s2  <= last_s1;
			end
			if (en3) begin
				out_valid <= valid_s2;
				if (sum > SAT_MAX) begin
					out_value <= SAT_MAX[DATA_W-1:0];
				end else if (sum < SAT_MIN) begin
					out_value <= SAT_MIN[DATA_W-1:0];
				end else begin
					out_value <= sum[DATA_W-1:0];
				end
				out_row  <= row_s2;
				out_col  <= col_s2;
				out_last <= last_s2;
			end
		end
	end

endmodule

### sv/heat_diffusion_stencil_2d.sv
`timescale 1ns / 1ps
// Top level of the 2D heat diffusion stencil: register file, front end, queue, back end.
// Depends on hds_pkg, hds_front, hds_queue and hds_back.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tdata: cell_value
//  m_axis   | out       | m_axis_tvalid/tready      | tdata: new_value, out_row, out_col;
//           |           |                           | tlast: last_cell
//  apb      | in        | psel/penable/pready       | grid_rows @0, grid_cols @4, gain @8
//
// One cell is taken per clock while s_axis_tready is high; the line buffer RAM is
// read on accept and written as the front-end stage register advances, which holds
// the rate at one item per cycle. The completing cell passes that register, the queue
// and the back-end s1, s2 and output registers before m_axis_tvalid rises.
// Reset clears the position counters, window and pipeline valids; the line
// buffers are not cleared and hold valid data once the first two rows have passed.
// A stalled output fills the back end and then the four-entry queue before
// s_axis_tready drops; boundary cells pass through even while the queue is full.
module heat_diffusion_stencil_2d
	import hds_pkg::*;
#(
	parameter int unsigned MAX_COLS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [31:0]        s_axis_tdata,   // [31:0] cell_value
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [63:0]        m_axis_tdata,   // [31:0] new_value, [47:32] out_row,
	                                           // [57:48] out_col, [63:58] zero
	output logic               m_axis_tlast,   // last_cell
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int unsigned CW  = $clog2(MAX_COLS);
	localparam int unsigned LMW = 17;

	logic [ROW_W-1:0]      grid_rows_q;
	logic [COLS_CFG_W-1:0] grid_cols_q;
	logic [GAIN_W-1:0]     gain_q;
	reg_idx_t              reg_idx;
	logic                  wr_en;

	logic [ROW_W-1:0]      rows_eff;
	logic [LMW-1:0]        cols_eff;
	logic [ROW_W-1:0]      last_row;
	logic [LMW-1:0]        last_col_w;

	logic                  push;
	stencil_t              push_item;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	stencil_t              q_head;

	logic [DATA_W-1:0]     out_value;
	logic [ROW_W-1:0]      out_row;
	logic [COL_OUT_W-1:0]  out_col;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_GRID_ROWS: prdata = PDATA_W'(grid_rows_q);
			REG_GRID_COLS: prdata = PDATA_W'(grid_cols_q);
			REG_GAIN:      prdata = PDATA_W'(gain_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ROWS_RESET;
			grid_cols_q <= COLS_RESET;
			gain_q      <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GRID_ROWS: grid_rows_q <= pwdata[ROW_W-1:0];
				REG_GRID_COLS: grid_cols_q <= pwdata[COLS_CFG_W-1:0];
				REG_GAIN:      gain_q      <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Grids below three rows or columns act as three; columns stop at the buffer depth.
	always_comb begin
		rows_eff = (grid_rows_q < ROW_W'(3)) ? ROW_W'(3) : grid_rows_q;
		cols_eff = (grid_cols_q < COLS_CFG_W'(3)) ? LMW'(3) : LMW'(grid_cols_q);
		if (cols_eff > LMW'(MAX_COLS)) begin
			cols_eff = LMW'(MAX_COLS);
		end
		last_row   = rows_eff - 1'b1;
		last_col_w = cols_eff - 1'b1;
	end

	hds_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cell   (s_axis_tdata),
		.last_row  (last_row),
		.last_col  (last_col_w[CW-1:0]),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	hds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	hds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, out_col, out_row, out_value};

endmodule
